[hw/rtl/lz4_optimal_parse_selector_unit_macros.svh]
// Assertion macros used by the checker file of the optimal-parse selector.
// No dependencies; included by bare file name.
`ifndef LZ4_OPTIMAL_PARSE_SELECTOR_UNIT_MACROS_SVH
`define LZ4_OPTIMAL_PARSE_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LZOPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LZOPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lzops_pkg.sv]
// Package of the optimal-parse selector: payload types, codes, constants and
// small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package lzops_pkg;

   localparam int MAX_POSITIONS_DEF = 4096;
   localparam int TAIL_LITERALS_DEF = 5;
   localparam int MIN_MATCH         = 4;
   localparam int RUN_NIBBLE        = 15;
   localparam int TOKEN_OFFSET_BITS = 8 + 16;
   localparam int BYTE_BITS         = 8;
   localparam int SHORT_MATCH       = RUN_NIBBLE + MIN_MATCH - 1;
   localparam int WEIGHT_RATIO      = 1;
   localparam int WEIGHT_SPEED      = 5;
   localparam int TAIL_COST         = 8;
   localparam logic [19:0] COST_MAX  = 20'hFFFFF;
   localparam logic [15:0] SCORE_MAX = 16'hFFFF;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_FAVOR_RATIO    = 2'd0,
      CSR_SWITCH_PENALTY = 2'd1,
      CSR_LEAVE_ALONE    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_OUT,
      ST_FETCH,
      ST_SETUP,
      ST_CAND,
      ST_WRITE_BACK
   } state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [11:0] position;
      logic [15:0] match_length;
      logic [15:0] match_distance;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [15:0] chosen_length;
      logic [15:0] chosen_distance;
      logic [19:0] total_cost;
      logic        is_summary;
   } rsp_type;

   // Quotient by 255 through the reciprocal form; exact for x below 65535.
   function automatic logic [16:0] div255(input logic [16:0] x);
      logic [17:0] t;
      t = {1'b0, x} + 18'(x >> 8) + 18'd1;
      return 17'(t >> 8);
   endfunction

   // Bits taken by the length extension bytes for an excess over the nibble.
   function automatic logic [11:0] ext_bits(input logic [15:0] excess);
      logic [16:0] q;
      q = div255(17'(excess) - 17'(RUN_NIBBLE));
      if (excess < 16'(RUN_NIBBLE)) begin
         return 12'd0;
      end
      return 12'((q + 17'd1) << 3);
   endfunction

endpackage

[hw/rtl/lz4_optimal_parse_selector_unit.sv]
// Top level of the optimal-parse selector: position stores, backward pass
// sequencer and result register. Depends on lzops_pkg.
`timescale 1ns / 1ps
// A read result goes from the match store's read register to the result
// register. A load flagged last at a nonzero in-range position starts the
// backward pass, during which busy is high. A position below the last with no
// usable match goes through fetch, setup and write-back; one with candidates
// also tries each candidate length in the candidate state (the full length
// alone at or above leave_alone_length, otherwise every length from the clamped
// length, or from 18 when speed is favored and that length is 19 to 36, down
// to 4). Each store has a single read port, and the candidate pipeline drains
// before write-back. The summary beat follows the write of position 0. Results
// are strobed for one cycle on rsp_valid and cannot be held off.
module lz4_optimal_parse_selector_unit #(
   parameter int MAX_POSITIONS = lzops_pkg::MAX_POSITIONS_DEF,
   parameter int TAIL_LITERALS = lzops_pkg::TAIL_LITERALS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lzops_pkg::req_type req,
   output logic              rsp_valid,
   output lzops_pkg::rsp_type rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import lzops_pkg::*;

   localparam int AW = $clog2(MAX_POSITIONS);
   localparam int NW = AW + 1;
   localparam int PW = ((AW > 12) ? AW : 12) + 1;
   localparam int XW = ((NW > 16) ? NW : 16) + 2;

   logic [31:0] mem_ld [MAX_POSITIONS];
   logic [35:0] mem_cs [MAX_POSITIONS];
   logic [31:0] rd_ld_ff;
   logic [35:0] rd_cs_ff;

   logic          ld_we, cs_we;
   logic [AW-1:0] ld_waddr, ld_raddr, cs_waddr, cs_raddr;
   logic [31:0]   ld_wdata;
   logic [35:0]   cs_wdata;

   state_type state_ff, state_in;

   logic          favor_ff;
   logic [7:0]    pen_ff;
   logic [15:0]   leave_ff;
   logic [NW-1:0] n_ff, n_in, nms_ff, nms_in;
   logic [AW-1:0] i_ff, i_in;
   logic [15:0]   k_ff, k_in, kend_ff, kend_in, eval_k_ff, eval_k_in;
   logic          issue_ff, issue_in, eval_v_ff, eval_v_in, eval_blk_ff, eval_blk_in;
   logic [19:0]   bc_ff, bc_in, prev_cost_ff, prev_cost_in, total_ff, total_in;
   logic [15:0]   bs_ff, bs_in, prev_score_ff, prev_score_in;
   logic [15:0]   bl_ff, bl_in, dist_ff, dist_in;
   logic          prev_match_ff, prev_match_in, rd_blk_ff, rd_blk_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          accept;
   logic [PW-1:0] pos_ext;
   logic          pos_ok;

   assign accept  = start && (state_ff == ST_IDLE);
   assign pos_ext = PW'(req.position);
   assign pos_ok  = pos_ext < PW'(MAX_POSITIONS);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.opcode == OP_READ) begin
                  state_in = ST_READ_OUT;
               end else if (req.last && pos_ok && (pos_ext != '0)) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_READ_OUT:   state_in = ST_IDLE;
         ST_FETCH:      state_in = ST_SETUP;
         ST_SETUP:      state_in = issue_in ? ST_CAND : ST_WRITE_BACK;
         ST_CAND: begin
            if (!issue_ff && !eval_v_ff) begin
               state_in = ST_WRITE_BACK;
            end
         end
         ST_WRITE_BACK: state_in = (i_ff == '0) ? ST_IDLE : ST_FETCH;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls of the sequencer.
   always_comb begin
      logic [15:0]          len, mlen16, kstart, bdw;
      logic [NW-1:0]        lit_len;
      logic [16:0]          x, q;
      logic                 lit_hit;
      logic [21:0]          csum;
      logic [16:0]          ssum;
      logic signed [XW-1:0] lim, mlen;
      logic [19:0]          cst, c;
      logic [15:0]          sc, s;
      logic                 mt;

      len = 16'd0; mlen16 = 16'd0; kstart = 16'd0; bdw = 16'd0;
      lit_len = '0; x = '0; q = '0; lit_hit = 1'b0; csum = '0; ssum = '0;
      lim = '0; mlen = '0; cst = '0; c = '0; sc = '0; s = '0; mt = 1'b0;

      ld_we = 1'b0; ld_waddr = '0; ld_wdata = '0; ld_raddr = i_ff;
      cs_we = 1'b0; cs_waddr = '0; cs_wdata = '0; cs_raddr = i_ff;
      n_in = n_ff; nms_in = nms_ff; i_in = i_ff;
      k_in = k_ff; kend_in = kend_ff; issue_in = issue_ff;
      eval_v_in = 1'b0; eval_k_in = eval_k_ff; eval_blk_in = eval_blk_ff;
      bc_in = bc_ff; bs_in = bs_ff; bl_in = bl_ff; dist_in = dist_ff;
      prev_cost_in = prev_cost_ff; prev_score_in = prev_score_ff;
      prev_match_in = prev_match_ff; total_in = total_ff;
      rd_blk_in = rd_blk_ff; rsp_in = rsp_ff; rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.opcode == OP_READ)) begin
               ld_raddr  = pos_ext[AW-1:0];
               rd_blk_in = pos_ext < PW'(n_ff);
            end else if (accept && pos_ok) begin
               ld_we    = 1'b1;
               ld_waddr = pos_ext[AW-1:0];
               ld_wdata = {req.match_length, req.match_distance};
               if (req.last) begin
                  // The last position is fixed as a literal tail of cost 8.
                  cs_we         = 1'b1;
                  cs_waddr      = pos_ext[AW-1:0];
                  cs_wdata      = {20'(TAIL_COST), 16'd0};
                  n_in          = NW'(pos_ext + PW'(1));
                  nms_in        = NW'(pos_ext + PW'(1));
                  i_in          = AW'(pos_ext - PW'(1));
                  prev_cost_in  = 20'(TAIL_COST);
                  prev_score_in = 16'd0;
                  prev_match_in = req.match_length >= 16'(MIN_MATCH);
                  if (pos_ext == '0) begin
                     total_in     = 20'(TAIL_COST);
                     rsp_in       = '{req.match_length, req.match_distance,
                                      20'(TAIL_COST), 1'b1};
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_READ_OUT: begin
            rsp_in.chosen_length   = rd_blk_ff ? rd_ld_ff[31:16] : 16'd0;
            rsp_in.chosen_distance = rd_blk_ff ? rd_ld_ff[15:0] : 16'd0;
            rsp_in.total_cost      = total_ff;
            rsp_in.is_summary      = 1'b0;
            rsp_valid_in           = 1'b1;
         end
         ST_FETCH: begin
            ld_raddr = i_ff;
         end
         ST_SETUP: begin
            len     = rd_ld_ff[31:16];
            dist_in = rd_ld_ff[15:0];
            // Literal: an extra byte when the literal run crosses a 255 step.
            lit_len = nms_ff - NW'(i_ff);
            x       = 17'(lit_len) - 17'(RUN_NIBBLE);
            q       = div255(x);
            lit_hit = (lit_len >= NW'(RUN_NIBBLE)) && (x == ((q << 8) - q));
            csum    = 22'(prev_cost_ff) + 22'(BYTE_BITS) +
                      (lit_hit ? 22'(BYTE_BITS) : 22'd0) +
                      (prev_match_ff ? 22'(pen_ff) : 22'd0);
            bc_in   = (csum > 22'(COST_MAX)) ? COST_MAX : csum[19:0];
            ssum    = 17'(prev_score_ff) + 17'd1;
            bs_in   = (ssum > 17'(SCORE_MAX)) ? SCORE_MAX : ssum[15:0];
            bl_in   = 16'd0;
            lim     = $signed(XW'(n_ff)) - $signed(XW'(TAIL_LITERALS)) -
                      $signed(XW'(i_ff));
            mlen    = ($signed(XW'(len)) > lim) ? lim : $signed(XW'(len));
            mlen16  = mlen[15:0];
            issue_in = 1'b0;
            if ((len >= 16'(MIN_MATCH)) && (mlen >= $signed(XW'(MIN_MATCH)))) begin
               issue_in = 1'b1;
               if (len >= leave_ff) begin
                  k_in    = mlen16;
                  kend_in = mlen16;
               end else begin
                  kstart = mlen16;
                  if (!favor_ff && (mlen16 > 16'(SHORT_MATCH)) &&
                      (mlen16 <= 16'(2 * SHORT_MATCH))) begin
                     kstart = 16'(SHORT_MATCH);
                  end
                  k_in    = kstart;
                  kend_in = 16'(MIN_MATCH);
               end
            end
         end
         ST_CAND: begin
            // Candidate lengths are read one per cycle, each evaluated in the next cycle.
            if (issue_ff) begin
               ld_raddr    = AW'(XW'(i_ff) + XW'(k_ff));
               cs_raddr    = AW'(XW'(i_ff) + XW'(k_ff));
               eval_v_in   = 1'b1;
               eval_k_in   = k_ff;
               eval_blk_in = (XW'(i_ff) + XW'(k_ff)) < XW'(n_ff);
               if (k_ff == kend_ff) begin
                  issue_in = 1'b0;
               end else begin
                  k_in = k_ff - 16'd1;
               end
            end
            if (eval_v_ff) begin
               cst  = eval_blk_ff ? rd_cs_ff[35:16] : 20'd0;
               sc   = eval_blk_ff ? rd_cs_ff[15:0] : 16'd0;
               mt   = eval_blk_ff && (rd_ld_ff[31:16] >= 16'(MIN_MATCH));
               csum = 22'(TOKEN_OFFSET_BITS) +
                      22'(ext_bits(eval_k_ff - 16'(MIN_MATCH))) + 22'(cst) +
                      (mt ? 22'(pen_ff) : 22'd0);
               c    = (csum > 22'(COST_MAX)) ? COST_MAX : csum[19:0];
               ssum = 17'(sc) + (favor_ff ? 17'(WEIGHT_RATIO) : 17'(WEIGHT_SPEED));
               s    = (ssum > 17'(SCORE_MAX)) ? SCORE_MAX : ssum[15:0];
               if ((bc_ff > c) || ((bc_ff == c) && (bs_ff > s))) begin
                  bc_in = c;
                  bs_in = s;
                  bl_in = eval_k_ff;
               end
            end
         end
         ST_WRITE_BACK: begin
            bdw           = (bl_ff >= 16'(MIN_MATCH)) ? dist_ff : 16'd0;
            ld_we         = 1'b1;
            ld_waddr      = i_ff;
            ld_wdata      = {bl_ff, bdw};
            cs_we         = 1'b1;
            cs_waddr      = i_ff;
            cs_wdata      = {bc_ff, bs_ff};
            prev_cost_in  = bc_ff;
            prev_score_in = bs_ff;
            prev_match_in = bl_ff >= 16'(MIN_MATCH);
            if (bl_ff >= 16'(MIN_MATCH)) begin
               nms_in = NW'(i_ff);
            end
            if (i_ff == '0) begin
               total_in     = bc_ff;
               rsp_in       = '{bl_ff, bdw, bc_ff, 1'b1};
               rsp_valid_in = 1'b1;
            end else begin
               i_in = i_ff - AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         mem_ld[ld_waddr] <= ld_wdata;
      end
      rd_ld_ff <= mem_ld[ld_raddr];
   end

   always_ff @(posedge clock) begin
      if (cs_we) begin
         mem_cs[cs_waddr] <= cs_wdata;
      end
      rd_cs_ff <= mem_cs[cs_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         favor_ff     <= 1'b0;
         pen_ff       <= 8'd1;
         leave_ff     <= 16'd1000;
         n_ff         <= '0;
         nms_ff       <= '0;
         total_ff     <= '0;
         issue_ff     <= 1'b0;
         eval_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         nms_ff       <= nms_in;
         total_ff     <= total_in;
         issue_ff     <= issue_in;
         eval_v_ff    <= eval_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FAVOR_RATIO:    favor_ff <= csr_wdata[0];
               CSR_SWITCH_PENALTY: pen_ff   <= csr_wdata[7:0];
               CSR_LEAVE_ALONE:    leave_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      k_ff          <= k_in;
      kend_ff       <= kend_in;
      eval_k_ff     <= eval_k_in;
      eval_blk_ff   <= eval_blk_in;
      bc_ff         <= bc_in;
      bs_ff         <= bs_in;
      bl_ff         <= bl_in;
      dist_ff       <= dist_in;
      prev_cost_ff  <= prev_cost_in;
      prev_score_ff <= prev_score_in;
      prev_match_ff <= prev_match_in;
      rd_blk_ff     <= rd_blk_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[hw/rtl/lzops_checker.sv]
// Port checker of the optimal-parse selector and its bind to the top level.
// Depends on lzops_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lz4_optimal_parse_selector_unit_macros.svh"
module lzops_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input lzops_pkg::req_type req,
   input logic               rsp_valid,
   input lzops_pkg::rsp_type rsp
);
   import lzops_pkg::*;

   logic read_acc;
   assign read_acc = start && !busy && (req.opcode == OP_READ);

   // A taken read comes back as a read beat, through the match store read register and the result register.
   `LZOPS_ASSERT_IMPLY(a_read_beat, clock, reset, $past(read_acc, 2) && !$past(reset) && !$past(reset, 2), rsp_valid && !rsp.is_summary, "read beat missing")
   // The summary beat marks the end of the pass.
   `LZOPS_ASSERT_IMPLY(a_summary_idle, clock, reset, rsp_valid && rsp.is_summary, !busy, "busy during summary beat")
   // The block turns busy only after taking an item.
   `LZOPS_ASSERT_IMPLY(a_busy_rise, clock, reset, busy && !$past(busy) && !$past(reset), $past(start), "busy rose without an item")
   // A beat seen while busy, outside a read, must be followed by busy going low.
   `LZOPS_ASSERT_NEXT(a_pass_end, clock, reset, busy && !read_acc && ($past(busy) && !$past(read_acc)) && rsp_valid, !busy, "busy after a beat")

endmodule

bind lz4_optimal_parse_selector_unit lzops_checker u_lzops_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
